// File: sv/smr_pkg.sv
// Shared types, constants and helpers of the sparse momentum row update block.
// Depends on nothing; smr_if, smr_front, smr_back, the top level and the checker use it.
`default_nettype none

package smr_pkg;

  localparam int unsigned MAX_ROWS_DEF = 1024;
  localparam int unsigned MAX_COLS_DEF = 64;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned ROWCNT_W    = 11;
  localparam int unsigned ROWLEN_W    = 7;
  localparam int unsigned COL_W       = 6;
  localparam int unsigned ROWIDX_W    = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned REGIDX_W    = PADDR_W - 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned PROD_W = COEF_W + 1 + VALUE_WIDTH;
  localparam int unsigned SH_W   = PROD_W - FRAC_W;
  localparam int unsigned SUM_W  = VALUE_WIDTH + 2;

  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_ROW = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_COL = 2'd2;

  localparam logic [REGIDX_W-1:0] REG_LR   = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_MOM  = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_NEST = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_ROWS = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_LEN  = 3'd4;

  localparam logic [ROWCNT_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [ROWLEN_W-1:0] LEN_RESET  = 7'd64;

  localparam logic signed [SUM_W-1:0] VAL_MAX =
    (SUM_W'(1) <<< (VALUE_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] VAL_MIN = -VAL_MAX - SUM_W'(1);

  typedef struct packed {
    logic [COEF_W-1:0]   lr;
    logic [COEF_W-1:0]   mom;
    logic                nest;
    logic [ROWCNT_W-1:0] row_count;
    logic [ROWLEN_W-1:0] row_length;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]                op;
    logic [ST_W-1:0]                status;
    logic                           skip;
    logic signed [VALUE_WIDTH-1:0]  grad;
    logic signed [VALUE_WIDTH-1:0]  load_p;
    logic signed [VALUE_WIDTH-1:0]  load_v;
  } entry_t;

  typedef struct packed {
    logic                          sat;
    logic signed [VALUE_WIDTH-1:0] val;
  } clip_t;

  function automatic clip_t sat_clip(input logic signed [SUM_W-1:0] x);
    clip_t r;
    r.sat = 1'b0;
    r.val = x[VALUE_WIDTH-1:0];
    if (x > VAL_MAX) begin
      r.sat = 1'b1;
      r.val = VAL_MAX[VALUE_WIDTH-1:0];
    end else if (x < VAL_MIN) begin
      r.sat = 1'b1;
      r.val = VAL_MIN[VALUE_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/smr_if.sv
// Handshake interfaces for the item channel and the result channel.
// Depends on smr_pkg for the field widths.
`default_nettype none

interface smr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [smr_pkg::OP_W-1:0]               opcode;
  logic signed [smr_pkg::ROWIDX_W-1:0]    row_index;
  logic [smr_pkg::COL_W-1:0]              column_index;
  logic signed [smr_pkg::VALUE_WIDTH-1:0] grad_value;
  logic signed [smr_pkg::VALUE_WIDTH-1:0] load_param;
  logic signed [smr_pkg::VALUE_WIDTH-1:0] load_velocity;

  modport source (output valid, opcode, row_index, column_index, grad_value,
                  load_param, load_velocity, input ready);
  modport sink (input valid, opcode, row_index, column_index, grad_value,
                load_param, load_velocity, output ready);
endinterface

interface smr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [smr_pkg::VALUE_WIDTH-1:0] param_out;
  logic signed [smr_pkg::VALUE_WIDTH-1:0] velocity_out;
  logic [smr_pkg::ST_W-1:0]               status;
  logic                                   saturated;

  modport source (output valid, param_out, velocity_out, status, saturated,
                  input ready);
  modport sink (input valid, param_out, velocity_out, status, saturated,
                output ready);
endinterface

`default_nettype wire

// File: sv/smr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module smr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AW-1:0]            waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/smr_front.sv
// Front end: accepts items, checks row and column against the geometry and
// forms the table address. Depends on smr_pkg and smr_if.
`default_nettype none

module smr_front #(
  parameter int unsigned MAX_ROWS = smr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smr_pkg::MAX_COLS_DEF,
  localparam int unsigned ADDR_W =
    (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  smr_pkg::cfg_t      cfg_i,
  smr_in_if.sink             in_i,
  output logic               push_valid_o,
  input  wire logic          push_ready_i,
  output smr_pkg::entry_t    entry_o,
  output logic [ADDR_W-1:0]  addr_o
);

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned LIN_W  = ROW_W + smr_pkg::ROWLEN_W;

  logic [smr_pkg::ROWCNT_W-1:0] rows_eff;
  logic [smr_pkg::ROWLEN_W-1:0] len_eff;
  logic                         bad_row;
  logic                         bad_col;
  logic                         bad_op;
  logic [LIN_W-1:0]             lin;

  assign rows_eff = (32'(cfg_i.row_count) > 32'(MAX_ROWS)) ?
                    smr_pkg::ROWCNT_W'(MAX_ROWS) : cfg_i.row_count;
  assign len_eff  = (32'(cfg_i.row_length) > 32'(MAX_COLS)) ?
                    smr_pkg::ROWLEN_W'(MAX_COLS) : cfg_i.row_length;

  assign bad_op  = (in_i.opcode == smr_pkg::OP_NONE);
  assign bad_row = in_i.row_index[smr_pkg::ROWIDX_W-1] ||
                   ($unsigned(in_i.row_index) >= smr_pkg::ROWIDX_W'(rows_eff));
  assign bad_col = (smr_pkg::ROWLEN_W'(in_i.column_index) >= len_eff);

  assign lin = LIN_W'(in_i.row_index[ROW_W-1:0]) * LIN_W'(len_eff) +
               LIN_W'(in_i.column_index);

  always_comb begin
    entry_o.op     = in_i.opcode;
    entry_o.grad   = in_i.grad_value;
    entry_o.load_p = in_i.load_param;
    entry_o.load_v = in_i.load_velocity;
    entry_o.skip   = bad_op || bad_row || bad_col;
    if (bad_op) begin
      entry_o.status = smr_pkg::ST_DONE;
    end else if (bad_row) begin
      entry_o.status = smr_pkg::ST_BAD_ROW;
    end else if (bad_col) begin
      entry_o.status = smr_pkg::ST_BAD_COL;
    end else begin
      entry_o.status = smr_pkg::ST_DONE;
    end
  end

  assign addr_o       = ADDR_W'(lin);
  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule

`default_nettype wire

// File: sv/smr_queue.sv
// Short first-in first-out queue that parts the front end from the back end.
// Depends on nothing.
`default_nettype none

module smr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/smr_back.sv
// Back end: sequencer that writes, reads or updates an entry (read, momentum update,
// write back) and holds the result. Depends on smr_pkg, smr_if, smr_ram.
`default_nettype none

module smr_back #(
  parameter int unsigned MAX_ROWS = smr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smr_pkg::MAX_COLS_DEF,
  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  smr_pkg::cfg_t          cfg_i,
  input  wire logic              pop_valid_i,
  output logic                   pop_ready_o,
  input  smr_pkg::entry_t        pop_entry_i,
  input  wire logic [ADDR_W-1:0] pop_addr_i,
  smr_out_if.source              out_o
);

  localparam int unsigned VW     = smr_pkg::VALUE_WIDTH;
  localparam int unsigned PW     = smr_pkg::PROD_W;
  localparam int unsigned SW     = smr_pkg::SUM_W;
  localparam int unsigned FW     = smr_pkg::FRAC_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_VEL   = 7'b0000100,
    S_NEST  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_PARAM = 7'b0100000,
    S_OUT   = 7'b1000000
  } back_state_e;

  back_state_e                state_q, state_d;
  smr_pkg::entry_t            ent_q, ent_d;
  logic [ADDR_W-1:0]          addr_q, addr_d;
  logic signed [VW-1:0]       p_q, p_d;
  logic signed [VW-1:0]       v_q, v_d;
  logic signed [VW-1:0]       step_q, step_d;
  logic signed [PW-1:0]       mvp_q, mvp_d;
  logic signed [PW-1:0]       lgp_q, lgp_d;
  logic                       sat_q, sat_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [VW-1:0]       out_p_q, out_p_d;
  logic signed [VW-1:0]       out_v_q, out_v_d;
  logic [smr_pkg::ST_W-1:0]   out_st_q, out_st_d;
  logic                       out_sat_q, out_sat_d;

  logic signed [VW-1:0]       mul_v;
  logic signed [PW-1:0]       mv_prod;
  logic signed [PW-1:0]       lg_prod;
  logic signed [smr_pkg::SH_W-1:0] mv_sh;
  logic signed [smr_pkg::SH_W-1:0] lg_sh;
  smr_pkg::clip_t             diff_clip;
  smr_pkg::clip_t             sum_clip;

  logic                       ram_we;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [VW-1:0]              ram_wdata_p;
  logic [VW-1:0]              ram_wdata_v;
  logic [VW-1:0]              ram_rdata_p;
  logic [VW-1:0]              ram_rdata_v;
  logic                       pop;

  assign pop         = pop_valid_i && (state_q == S_IDLE);
  assign pop_ready_o = (state_q == S_IDLE);

  assign mul_v   = (state_q == S_FETCH) ? $signed(ram_rdata_v) : v_q;
  assign mv_prod = $signed({1'b0, cfg_i.mom}) * mul_v;
  assign lg_prod = $signed({1'b0, cfg_i.lr}) * ent_q.grad;

  assign mv_sh     = mvp_q[PW-1:FW];
  assign lg_sh     = lgp_q[PW-1:FW];
  assign diff_clip = smr_pkg::sat_clip(SW'(mv_sh) - SW'(lg_sh));
  assign sum_clip  = smr_pkg::sat_clip(SW'(p_q) + SW'(step_q));

  always_comb begin
    ram_re      = pop && !pop_entry_i.skip && (pop_entry_i.op != smr_pkg::OP_WRITE);
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata_p = sum_clip.val;
    ram_wdata_v = v_q;
    if (pop && !pop_entry_i.skip && (pop_entry_i.op == smr_pkg::OP_WRITE)) begin
      ram_we      = 1'b1;
      ram_waddr   = pop_addr_i;
      ram_wdata_p = pop_entry_i.load_p;
      ram_wdata_v = pop_entry_i.load_v;
    end else if (state_q == S_PARAM) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    addr_d      = addr_q;
    p_d         = p_q;
    v_d         = v_q;
    step_d      = step_q;
    mvp_d       = mvp_q;
    lgp_d       = lgp_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_p_d     = out_p_q;
    out_v_d     = out_v_q;
    out_st_d    = out_st_q;
    out_sat_d   = out_sat_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          ent_d  = pop_entry_i;
          addr_d = pop_addr_i;
          sat_d  = 1'b0;
          if (pop_entry_i.skip) begin
            p_d     = '0;
            v_d     = '0;
            state_d = S_OUT;
          end else if (pop_entry_i.op == smr_pkg::OP_WRITE) begin
            p_d     = pop_entry_i.load_p;
            v_d     = pop_entry_i.load_v;
            state_d = S_OUT;
          end else begin
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        p_d     = $signed(ram_rdata_p);
        v_d     = $signed(ram_rdata_v);
        mvp_d   = mv_prod;
        lgp_d   = lg_prod;
        state_d = (ent_q.op == smr_pkg::OP_READ) ? S_OUT : S_VEL;
      end
      S_VEL: begin
        v_d     = diff_clip.val;
        sat_d   = sat_q || diff_clip.sat;
        state_d = cfg_i.nest ? S_NEST : S_STEP;
      end
      S_NEST: begin
        mvp_d   = mv_prod;
        state_d = S_STEP;
      end
      S_STEP: begin
        if (cfg_i.nest) begin
          step_d = diff_clip.val;
          sat_d  = sat_q || diff_clip.sat;
        end else begin
          step_d = v_q;
        end
        state_d = S_PARAM;
      end
      S_PARAM: begin
        p_d     = sum_clip.val;
        sat_d   = sat_q || sum_clip.sat;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_p_d     = p_q;
          out_v_d     = v_q;
          out_st_d    = ent_q.status;
          out_sat_d   = sat_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    addr_q    <= addr_d;
    p_q       <= p_d;
    v_q       <= v_d;
    step_q    <= step_d;
    mvp_q     <= mvp_d;
    lgp_q     <= lgp_d;
    sat_q     <= sat_d;
    out_p_q   <= out_p_d;
    out_v_q   <= out_v_d;
    out_st_q  <= out_st_d;
    out_sat_q <= out_sat_d;
  end

  smr_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_param_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_p),
    .re_i    (ram_re),
    .raddr_i (pop_addr_i),
    .rdata_o (ram_rdata_p)
  );

  smr_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_velocity_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_v),
    .re_i    (ram_re),
    .raddr_i (pop_addr_i),
    .rdata_o (ram_rdata_v)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.param_out    = out_p_q;
  assign out_o.velocity_out = out_v_q;
  assign out_o.status       = out_st_q;
  assign out_o.saturated    = out_sat_q;

endmodule

`default_nettype wire

// File: sv/sparse_momentum_row_update.sv
// The back end handles one word at a time, with a write and a read port per table.
// An update passes the fetch, velocity, Nesterov (if enabled), step, parameter and
// output states, a read fetch and output, and a write or an ignored word output only,
// once the word leaves the two-word queue. The front end takes a new word every cycle
// while the queue has room, and a waiting result stalls the next word only at output.
// Top level: APB register file, front end, queue and back end.
// Depends on smr_pkg, smr_if, smr_front, smr_queue, smr_back and smr_ram.
`default_nettype none

module sparse_momentum_row_update #(
  parameter int unsigned MAX_ROWS = smr_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = smr_pkg::MAX_COLS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  smr_in_if.sink                            in_i,
  smr_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [smr_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [smr_pkg::PDATA_W-1:0]  pwdata,
  output      logic [smr_pkg::PDATA_W-1:0]  prdata,
  output      logic                         pready
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ENT_W  = $bits(smr_pkg::entry_t);
  localparam int unsigned Q_W    = ENT_W + ADDR_W;

  smr_pkg::cfg_t                     cfg_q, cfg_d;
  logic [smr_pkg::REGIDX_W-1:0]      reg_idx;
  logic                              cfg_we;

  logic                              push_valid;
  logic                              push_ready;
  smr_pkg::entry_t                   push_entry;
  logic [ADDR_W-1:0]                 push_addr;
  logic                              pop_valid;
  logic                              pop_ready;
  logic [Q_W-1:0]                    pop_data;
  smr_pkg::entry_t                   pop_entry;
  logic [ADDR_W-1:0]                 pop_addr;

  assign reg_idx = paddr[smr_pkg::PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_idx)
        smr_pkg::REG_LR:   cfg_d.lr         = pwdata[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_MOM:  cfg_d.mom        = pwdata[smr_pkg::COEF_W-1:0];
        smr_pkg::REG_NEST: cfg_d.nest       = pwdata[0];
        smr_pkg::REG_ROWS: cfg_d.row_count  = pwdata[smr_pkg::ROWCNT_W-1:0];
        smr_pkg::REG_LEN:  cfg_d.row_length = pwdata[smr_pkg::ROWLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      smr_pkg::REG_LR:   prdata = smr_pkg::PDATA_W'(cfg_q.lr);
      smr_pkg::REG_MOM:  prdata = smr_pkg::PDATA_W'(cfg_q.mom);
      smr_pkg::REG_NEST: prdata = smr_pkg::PDATA_W'(cfg_q.nest);
      smr_pkg::REG_ROWS: prdata = smr_pkg::PDATA_W'(cfg_q.row_count);
      smr_pkg::REG_LEN:  prdata = smr_pkg::PDATA_W'(cfg_q.row_length);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lr         <= '0;
      cfg_q.mom        <= '0;
      cfg_q.nest       <= 1'b0;
      cfg_q.row_count  <= smr_pkg::ROWS_RESET;
      cfg_q.row_length <= smr_pkg::LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smr_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry),
    .addr_o       (push_addr)
  );

  smr_queue #(
    .WIDTH (Q_W),
    .DEPTH (smr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_addr, push_entry}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_entry = pop_data[ENT_W-1:0];
  assign pop_addr  = pop_data[Q_W-1:ENT_W];

  smr_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .pop_addr_i  (pop_addr),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: sv/smr_checker.sv
// Port-level checks of the sparse momentum row update block, bound to its top level.
// Depends on smr_pkg and sparse_momentum_row_update.
`default_nettype none

module smr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic signed [smr_pkg::VALUE_WIDTH-1:0] out_param_i,
  input wire logic signed [smr_pkg::VALUE_WIDTH-1:0] out_velocity_i,
  input wire logic [smr_pkg::ST_W-1:0]          out_status_i,
  input wire logic                              out_sat_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before it was taken");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != smr_pkg::ST_DONE) |->
      (out_param_i == '0) && (out_velocity_i == '0) && !out_sat_i)
    else $error("ignored word carries nonzero payload");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind sparse_momentum_row_update smr_checker u_smr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_param_i    (out_o.param_out),
  .out_velocity_i (out_o.velocity_out),
  .out_status_i   (out_o.status),
  .out_sat_i      (out_o.saturated)
);

`default_nettype wire
